### src/wsts_pkg.sv
// Shared constants, types and helper functions of the work-stealing task scheduler.
package wsts_pkg;

  localparam int NUM_WORKERS  = 8;
  localparam int DEQUE_DEPTH  = 64;
  localparam int HANDLE_WIDTH = 16;

  localparam int MODE_W   = 2;
  localparam int WID_W    = 3;
  localparam int TASK_W   = 16;
  localparam int ACT_W    = 4;
  localparam int PEND_W   = 10;
  localparam int PEND_MAX = 1023;
  localparam int RING_SPAN = 2 * DEQUE_DEPTH;
  localparam int IDX_W    = $clog2(RING_SPAN);
  localparam int OCC_W    = IDX_W + 1;
  localparam int WSEL_W   = $clog2(NUM_WORKERS);
  localparam int CNT_W    = $clog2(NUM_WORKERS + 1);
  localparam int SLOTS    = NUM_WORKERS * DEQUE_DEPTH;
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(8);

  typedef enum logic [MODE_W-1:0] {
    MODE_SUBMIT   = 2'd0,
    MODE_FETCH    = 2'd1,
    MODE_COMPLETE = 2'd2,
    MODE_NOP      = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [OCC_W-1:0]        occ_t;
  typedef logic [PEND_W-1:0]       pend_t;
  typedef logic [WSEL_W-1:0]       wsel_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;

  function automatic idx_t ring_next(input idx_t i);
    ring_next = (int'(i) == RING_SPAN - 1) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t ring_prev(input idx_t i);
    ring_prev = (i == '0) ? idx_t'(RING_SPAN - 1) : idx_t'(i - 1'b1);
  endfunction

  function automatic occ_t occupancy(input idx_t b, input idx_t t);
    occ_t s;
    s = occ_t'(b) + occ_t'(RING_SPAN) - occ_t'(t);
    occupancy = (int'(s) >= RING_SPAN) ? occ_t'(s - occ_t'(RING_SPAN)) : s;
  endfunction

  function automatic addr_t slot_addr(input wsel_t w, input idx_t i);
    idx_t s;
    s = (int'(i) >= DEQUE_DEPTH) ? idx_t'(i - idx_t'(DEQUE_DEPTH)) : i;
    slot_addr = addr_t'(int'(w) * DEQUE_DEPTH + int'(s));
  endfunction

  function automatic pend_t pend_inc(input pend_t p);
    pend_inc = (int'(p) < PEND_MAX) ? pend_t'(p + 1'b1) : p;
  endfunction

  function automatic pend_t pend_dec(input pend_t p);
    pend_dec = (p != '0) ? pend_t'(p - 1'b1) : p;
  endfunction

endpackage

### src/wsts_ifs.sv
// Valid/ready channel interfaces for scheduler requests and results.
interface wsts_in_if;
  logic                          valid;
  logic                          ready;
  wsts_pkg::mode_t               mode;
  logic [wsts_pkg::WID_W-1:0]    worker_id;
  logic [wsts_pkg::TASK_W-1:0]   task_handle;

  modport source (output valid, mode, worker_id, task_handle, input ready);
  modport sink   (input valid, mode, worker_id, task_handle, output ready);
endinterface

interface wsts_out_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic [wsts_pkg::WID_W-1:0]    worker_out;
  logic [wsts_pkg::TASK_W-1:0]   task_out;
  logic                          was_stolen;

  modport source (output valid, success, worker_out, task_out, was_stolen, input ready);
  modport sink   (input valid, success, worker_out, task_out, was_stolen, output ready);
endinterface

### src/wsts_ram.sv
// Generic single-port synchronous RAM with registered read data.
module wsts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### src/work_stealing_task_scheduler_top.sv
// Top level of the work-stealing task scheduler: deque indexes, pending counts and control.
//
//   channel   direction  handshake                 payload
//   in_if     input      valid/ready               mode, worker_id, task_handle
//   out_if    output     valid/ready               success, worker_out, task_out, was_stolen
//   apb       input      psel/penable/pwrite       paddr, pwdata, prdata (active_workers)
//
// The accept cycle updates the deque indexes and pending counts and issues the task slot
// memory access; in the response state the output register is then loaded with the
// memory read data as soon as the output register is free.
// Reset is synchronous, clears indexes and counts, and sets the active worker register to 8.
// A stalled output holds the block in its response state until the output register frees.
module work_stealing_task_scheduler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  wsts_in_if.sink                         in_if,
  wsts_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wsts_pkg::PADDR_W-1:0]    paddr,
  input  logic [wsts_pkg::PDATA_W-1:0]    pwdata,
  output logic [wsts_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import wsts_pkg::*;

  state_t          state_r, state_nxt;
  logic [ACT_W-1:0] active_r;
  idx_t            bot_r [NUM_WORKERS];
  idx_t            top_r [NUM_WORKERS];
  pend_t           pend_r [NUM_WORKERS];
  idx_t            bot_nxt [NUM_WORKERS];
  idx_t            top_nxt [NUM_WORKERS];
  pend_t           pend_nxt [NUM_WORKERS];

  logic            rsp_success_r, rsp_success_nxt;
  logic [WID_W-1:0] rsp_worker_r, rsp_worker_nxt;
  logic            rsp_stolen_r, rsp_stolen_nxt;
  logic            rsp_read_r, rsp_read_nxt;

  logic            out_valid_r;
  logic            out_success_r;
  logic [WID_W-1:0] out_worker_r;
  logic [TASK_W-1:0] out_task_r;
  logic            out_stolen_r;

  logic            in_fire;
  logic            out_load;
  logic [CNT_W-1:0] n_act;
  occ_t            occ [NUM_WORKERS];
  logic            occ_ok;
  wsel_t           best;
  pend_t           low_pend;
  wsel_t           victim;
  logic            found;
  wsel_t           wsel;
  logic            wid_ok;
  idx_t            pop_idx;

  logic            ram_we, ram_re;
  addr_t           ram_addr;
  handle_t         ram_wdata, ram_rdata;

  wsts_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE) ? PDATA_W'(active_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_ACTIVE) begin
      active_r <= pwdata[ACT_W-1:0];
    end
  end

  assign in_fire = in_if.valid && in_if.ready;

  always_comb begin
    if (active_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(active_r) > NUM_WORKERS) begin
      n_act = CNT_W'(NUM_WORKERS);
    end else begin
      n_act = CNT_W'(active_r);
    end
  end

  always_comb begin
    occ_ok = 1'b1;
    for (int w = 0; w < NUM_WORKERS; w++) begin
      occ[w] = occupancy(bot_r[w], top_r[w]);
      if (int'(occ[w]) > DEQUE_DEPTH) begin
        occ_ok = 1'b0;
      end
    end
  end

  always_comb begin
    best     = '0;
    low_pend = pend_r[0];
    for (int i = 1; i < NUM_WORKERS; i++) begin
      if (i < int'(n_act) && pend_r[i] < low_pend) begin
        best     = wsel_t'(i);
        low_pend = pend_r[i];
      end
    end
  end

  assign wsel   = wsel_t'(in_if.worker_id);
  assign wid_ok = int'(in_if.worker_id) < NUM_WORKERS;

  always_comb begin
    victim = '0;
    found  = 1'b0;
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      if (i < int'(n_act) && i != int'(in_if.worker_id) && occ[i] != '0) begin
        victim = wsel_t'(i);
        found  = 1'b1;
      end
    end
  end

  assign pop_idx = ring_prev(bot_r[wsel]);

  always_comb begin
    bot_nxt         = bot_r;
    top_nxt         = top_r;
    pend_nxt        = pend_r;
    rsp_success_nxt = rsp_success_r;
    rsp_worker_nxt  = rsp_worker_r;
    rsp_stolen_nxt  = rsp_stolen_r;
    rsp_read_nxt    = rsp_read_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_addr        = '0;
    ram_wdata       = handle_t'(in_if.task_handle);
    if (in_fire) begin
      rsp_success_nxt = 1'b0;
      rsp_worker_nxt  = '0;
      rsp_stolen_nxt  = 1'b0;
      rsp_read_nxt    = 1'b0;
      unique case (in_if.mode)
        MODE_SUBMIT: begin
          rsp_worker_nxt = WID_W'(best);
          if (int'(occ[best]) < DEQUE_DEPTH) begin
            ram_we          = 1'b1;
            ram_addr        = slot_addr(best, bot_r[best]);
            bot_nxt[best]   = ring_next(bot_r[best]);
            pend_nxt[best]  = pend_inc(pend_r[best]);
            rsp_success_nxt = 1'b1;
          end
        end
        MODE_FETCH: begin
          if (wid_ok) begin
            if (occ[wsel] != '0) begin
              ram_re          = 1'b1;
              ram_addr        = slot_addr(wsel, pop_idx);
              bot_nxt[wsel]   = pop_idx;
              rsp_success_nxt = 1'b1;
              rsp_worker_nxt  = in_if.worker_id;
              rsp_read_nxt    = 1'b1;
            end else if (found) begin
              ram_re           = 1'b1;
              ram_addr         = slot_addr(victim, top_r[victim]);
              top_nxt[victim]  = ring_next(top_r[victim]);
              pend_nxt[victim] = pend_dec(pend_r[victim]);
              pend_nxt[wsel]   = pend_inc(pend_r[wsel]);
              rsp_success_nxt  = 1'b1;
              rsp_worker_nxt   = WID_W'(victim);
              rsp_stolen_nxt   = 1'b1;
              rsp_read_nxt     = 1'b1;
            end
          end
        end
        MODE_COMPLETE: begin
          if (wid_ok) begin
            pend_nxt[wsel] = pend_dec(pend_r[wsel]);
          end
        end
        MODE_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_if.ready = 1'b1;
      ST_RESP: out_load = !out_valid_r || out_if.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int w = 0; w < NUM_WORKERS; w++) begin
        bot_r[w]  <= '0;
        top_r[w]  <= '0;
        pend_r[w] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      bot_r   <= bot_nxt;
      top_r   <= top_nxt;
      pend_r  <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp_success_r <= rsp_success_nxt;
    rsp_worker_r  <= rsp_worker_nxt;
    rsp_stolen_r  <= rsp_stolen_nxt;
    rsp_read_r    <= rsp_read_nxt;
    if (out_load) begin
      out_success_r <= rsp_success_r;
      out_worker_r  <= rsp_worker_r;
      out_stolen_r  <= rsp_stolen_r;
      out_task_r    <= rsp_read_r ? TASK_W'(ram_rdata) : '0;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.success    = out_success_r;
  assign out_if.worker_out = out_worker_r;
  assign out_if.task_out   = out_task_r;
  assign out_if.was_stolen = out_stolen_r;

  a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_RESP)
    else $error("Accepted item did not move the control to the response state.");

  a_no_accept_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESP |-> !in_if.ready)
    else $error("Input taken while a response was still being formed.");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_ok)
    else $error("A deque holds more items than its depth.");

  a_stolen_needs_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.was_stolen |-> out_if.success)
    else $error("A stolen result was reported without success.");

  a_read_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> in_fire && in_if.mode == MODE_FETCH)
    else $error("Slot memory read issued outside a fetch.");

endmodule

### test/work_stealing_task_scheduler_top_test.sv
// Self-checking testbench for the work-stealing task scheduler with a built-in predictor.
module work_stealing_task_scheduler_top_test;
  import wsts_pkg::*;

  localparam int IDLE_PCT   = 19;
  localparam int HOLD_LEN   = 300;
  localparam int WATCH_DOG  = 5000;

  typedef struct packed {
    mode_t                mode;
    logic [WID_W-1:0]     wid;
    logic [TASK_W-1:0]    handle;
  } request_t;

  typedef struct packed {
    logic                 success;
    logic [WID_W-1:0]     worker_out;
    logic [TASK_W-1:0]    task_out;
    logic                 was_stolen;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic     drv_valid = 1'b0;
  request_t drv_item = '{mode: MODE_NOP, wid: '0, handle: '0};
  logic     take_ready = 1'b0;

  wsts_in_if  req_ch ();
  wsts_out_if res_ch ();

  assign req_ch.valid       = drv_valid;
  assign req_ch.mode        = drv_item.mode;
  assign req_ch.worker_id   = drv_item.wid;
  assign req_ch.task_handle = drv_item.handle;
  assign res_ch.ready       = take_ready;

  work_stealing_task_scheduler_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (req_ch),
    .out_if  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  handle_t          slot_mem [NUM_WORKERS][DEQUE_DEPTH];
  idx_t             bot_at [NUM_WORKERS];
  idx_t             top_at [NUM_WORKERS];
  pend_t            pend_of [NUM_WORKERS];
  logic [ACT_W-1:0] active_reg = ACTIVE_RESET;

  request_t request_q [$];
  result_t  answer_q [$];

  int fails = 0;
  int items_taken = 0;
  int results_checked = 0;
  int steals = 0;
  int rejects = 0;
  int empties = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  bit steady = 1'b0;
  bit flood = 1'b0;

  function automatic idx_t fill_of(input int w);
    return idx_t'(bot_at[w] - top_at[w]);
  endfunction

  function automatic idx_t step_up(input idx_t i);
    return (int'(i) == RING_SPAN - 1) ? idx_t'(0) : idx_t'(i + 1'b1);
  endfunction

  function automatic void bump(input int w);
    if (int'(pend_of[w]) < PEND_MAX) pend_of[w] = pend_of[w] + 1'b1;
  endfunction

  function automatic void drop(input int w);
    if (pend_of[w] != '0) pend_of[w] = pend_of[w] - 1'b1;
  endfunction

  function automatic result_t schedule_step(input request_t r);
    result_t a;
    int n;
    int w;
    int best;
    int victim;
    a = '0;
    w = int'(r.wid);
    n = (active_reg == '0) ? 1 : (int'(active_reg) > NUM_WORKERS) ? NUM_WORKERS
                                                                  : int'(active_reg);
    case (r.mode)
      MODE_SUBMIT: begin
        best = 0;
        for (int i = 1; i < n; i++) begin
          if (pend_of[i] < pend_of[best]) best = i;
        end
        a.worker_out = WID_W'(best);
        if (int'(fill_of(best)) < DEQUE_DEPTH) begin
          slot_mem[best][int'(bot_at[best]) % DEQUE_DEPTH] = r.handle;
          bot_at[best] = step_up(bot_at[best]);
          bump(best);
          a.success = 1'b1;
        end else begin
          rejects++;
        end
      end
      MODE_FETCH: begin
        if (fill_of(w) != '0) begin
          bot_at[w] = (bot_at[w] == '0) ? idx_t'(RING_SPAN - 1) : idx_t'(bot_at[w] - 1'b1);
          a.success = 1'b1;
          a.worker_out = r.wid;
          a.task_out = slot_mem[w][int'(bot_at[w]) % DEQUE_DEPTH];
        end else begin
          victim = -1;
          for (int i = 0; i < n; i++) begin
            if (victim < 0 && i != w && fill_of(i) != '0) victim = i;
          end
          if (victim >= 0) begin
            a.success = 1'b1;
            a.worker_out = WID_W'(victim);
            a.task_out = slot_mem[victim][int'(top_at[victim]) % DEQUE_DEPTH];
            a.was_stolen = 1'b1;
            top_at[victim] = step_up(top_at[victim]);
            drop(victim);
            bump(w);
            steals++;
          end else begin
            empties++;
          end
        end
      end
      MODE_COMPLETE: drop(w);
      default: ;
    endcase
    return a;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_ch.ready) begin
        answer_q.push_back(schedule_step(drv_item));
        items_taken++;
      end
      if (!drv_valid || req_ch.ready) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          drv_item <= request_q.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.success, res_ch.worker_out, res_ch.task_out, res_ch.was_stolen};
        if (answer_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result success=%0b worker=%0d task=%h stolen=%0b",
                   $time, got.success, got.worker_out, got.task_out, got.was_stolen);
        end else begin
          want = answer_q.pop_front();
          results_checked++;
          if (got.success !== want.success || got.worker_out !== want.worker_out ||
              got.task_out !== want.task_out || got.was_stolen !== want.was_stolen) begin
            fails++;
            $display("%0t: mismatch expected success=%0b worker=%0d task=%h stolen=%0b",
                     $time, want.success, want.worker_out, want.task_out, want.was_stolen);
            $display("%0t:          actual   success=%0b worker=%0d task=%h stolen=%0b",
                     $time, got.success, got.worker_out, got.task_out, got.was_stolen);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        take_ready <= 1'b0;
      end else if (flood && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN;
        take_ready <= 1'b0;
      end else begin
        take_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCH_DOG) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, WATCH_DOG);
    $display("** work_stealing_task_scheduler_top: FAILED **");
    $finish;
  end

  task automatic push_item(input mode_t m, input int w, input logic [TASK_W-1:0] h);
    request_q.push_back('{mode: m, wid: WID_W'(w), handle: h});
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || drv_valid || answer_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_active(input logic [ACT_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(REG_ACTIVE));
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    active_reg = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(v)) begin
      fails++;
      $display("%0t: register readback expected %h actual %h", $time, PDATA_W'(v), prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_mix(input int count);
    int made;
    int pick;
    int burst;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        burst = $urandom_range(8, 40);
        repeat (burst) push_item(MODE_SUBMIT, $urandom_range(7), TASK_W'($urandom));
        made += burst;
      end else begin
        if (pick < 42) push_item(MODE_SUBMIT, $urandom_range(7), TASK_W'($urandom));
        else if (pick < 77) push_item(MODE_FETCH, $urandom_range(7), TASK_W'($urandom));
        else if (pick < 95) push_item(MODE_COMPLETE, $urandom_range(7), TASK_W'($urandom));
        else push_item(MODE_NOP, $urandom_range(7), TASK_W'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    for (int w = 0; w < NUM_WORKERS; w++) begin
      bot_at[w] = '0;
      top_at[w] = '0;
      pend_of[w] = '0;
      for (int s = 0; s < DEQUE_DEPTH; s++) slot_mem[w][s] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_active(ACTIVE_RESET);

    push_item(MODE_COMPLETE, 0, 16'h0000);
    push_item(MODE_FETCH, 3, 16'h1234);
    push_item(MODE_NOP, 7, 16'hFFFF);
    push_item(MODE_SUBMIT, 7, 16'hFFFF);
    push_item(MODE_SUBMIT, 0, 16'h0000);
    push_item(MODE_SUBMIT, 5, 16'h8001);
    push_item(MODE_SUBMIT, 2, 16'h7FFE);
    push_item(MODE_FETCH, 0, 16'hFFFF);
    push_item(MODE_FETCH, 0, 16'h0000);
    push_item(MODE_FETCH, 7, 16'h0000);
    push_item(MODE_COMPLETE, 7, 16'hFFFF);
    push_item(MODE_COMPLETE, 7, 16'hFFFF);
    push_item(MODE_COMPLETE, 0, 16'h0000);
    push_item(MODE_SUBMIT, 0, 16'hAAAA);
    push_item(MODE_SUBMIT, 0, 16'h5555);
    push_item(MODE_NOP, 0, 16'h0000);
    push_item(MODE_FETCH, 7, 16'hFFFF);
    push_item(MODE_FETCH, 5, 16'h0000);
    push_item(MODE_FETCH, 6, 16'h0000);
    push_item(MODE_FETCH, 6, 16'h0000);
    push_item(MODE_FETCH, 2, 16'h0000);
    wait_idle();

    set_active(ACT_W'(1));
    repeat (70) push_item(MODE_SUBMIT, $urandom_range(7), TASK_W'($urandom));
    repeat (75) push_item(MODE_FETCH, $urandom_range(7), TASK_W'($urandom));
    wait_idle();

    set_active('0);
    queue_mix(60);
    wait_idle();

    set_active(ACT_W'(15));
    flood = 1'b1;
    queue_mix(250);
    wait_idle();
    flood = 1'b0;

    set_active(ACT_W'(3));
    repeat (4) push_item(MODE_FETCH, $urandom_range(3, 7), TASK_W'($urandom));
    queue_mix(150);
    wait_idle();

    set_active(ACT_W'(1));
    repeat (60) begin
      push_item(MODE_SUBMIT, $urandom_range(7), TASK_W'($urandom));
      push_item(MODE_FETCH, 0, TASK_W'($urandom));
    end
    push_item(MODE_SUBMIT, 4, 16'hC3C3);
    push_item(MODE_FETCH, 4, 16'h0000);
    repeat (3) push_item(MODE_COMPLETE, 0, 16'h0000);
    wait_idle();

    set_active(ACTIVE_RESET);
    steady = 1'b1;
    queue_mix(300);
    wait_idle();
    steady = 1'b0;

    set_active(ACT_W'($urandom_range(1, NUM_WORKERS)));
    queue_mix(150);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Ran %0d items under eight worker-count settings, zero and fifteen included.",
             items_taken);
    $display("Checked %0d results: %0d steals, %0d full-deque rejects, %0d empty fetches.",
             results_checked, steals, rejects, empties);
    if (fails == 0) begin
      $display("** work_stealing_task_scheduler_top: PASSED **");
    end else begin
      $display("** work_stealing_task_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
